FILE: rtl/pmqr_pkg.sv
// Shared types, constants and helpers of the palette quad reducer.
// Used by the channel interfaces, the search cell, the cell chain and the top level.
package pmqr_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;

    localparam int unsigned IDX_W  = 8;
    localparam int unsigned COL_W  = 8;
    localparam int unsigned RGB_W  = 3 * COL_W;
    localparam int unsigned QUAD   = 4;
    localparam int unsigned SEE_W  = 3;
    localparam int unsigned SUM_W  = 10;
    localparam int unsigned SQ_W   = 16;
    localparam int unsigned DIST_W = 18;

    localparam logic [IDX_W-1:0]  CLEAR_INDEX = 8'd255;
    localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [SEE_W-1:0]  SEE_ONE     = 3'd1;
    localparam logic [SEE_W-1:0]  SEE_TWO     = 3'd2;

    // floor(x / 3) == (x * 683) >> 11 for every x below 2046.
    localparam int unsigned RECIP3_W  = 11;
    localparam int unsigned RECIP3_SH = 11;
    localparam logic [RECIP3_W-1:0] RECIP3 = 11'd683;
    localparam int unsigned PROD_W = SUM_W + RECIP3_W;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_REDUCE = 1'b1
    } t_cmd;

    typedef enum logic {
        PASS_GATHER = 1'b0,
        PASS_SEARCH = 1'b1
    } t_pass;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_GATHER = 2'd1,
        ST_SEARCH = 2'd2,
        ST_FINISH = 2'd3
    } t_state;

    // Item travelling down the row of cells. The gather pass collects the
    // colour sums of the quad, the search pass keeps the best match so far.
    typedef struct packed {
        logic                       vld;
        t_pass                      phase;
        logic [QUAD-1:0][IDX_W-1:0] pix;
        logic [QUAD-1:0]            act;
        logic [SUM_W-1:0]           sum_r;
        logic [SUM_W-1:0]           sum_g;
        logic [SUM_W-1:0]           sum_b;
        logic [COL_W-1:0]           avg_r;
        logic [COL_W-1:0]           avg_g;
        logic [COL_W-1:0]           avg_b;
        logic [DIST_W-1:0]          best_d;
        logic [IDX_W-1:0]           best_idx;
        logic                       clear;
    } t_token;

    // Palette write broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
    } t_wr;

    // Average of three or four opaque colour values, floor division.
    function automatic logic [COL_W-1:0] avg_of(input logic [SUM_W-1:0] sum,
                                                input logic div3);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        begin
            prod = PROD_W'(sum) * PROD_W'(RECIP3);
            quot = prod >> RECIP3_SH;
            if (div3) begin
                avg_of = quot[COL_W-1:0];
            end else begin
                avg_of = sum[SUM_W-1:2];
            end
        end
    endfunction

endpackage

FILE: rtl/pmqr_chan_if.sv
// Handshake channels of the palette quad reducer: input items, results and
// the configuration write. Depends on pmqr_pkg for field widths.
interface pmqr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [pmqr_pkg::IDX_W-1:0]    entry_index;
    logic [pmqr_pkg::COL_W-1:0]    entry_red;
    logic [pmqr_pkg::COL_W-1:0]    entry_green;
    logic [pmqr_pkg::COL_W-1:0]    entry_blue;
    logic [pmqr_pkg::IDX_W-1:0]    pixel_top_left;
    logic [pmqr_pkg::IDX_W-1:0]    pixel_top_right;
    logic [pmqr_pkg::IDX_W-1:0]    pixel_bottom_left;
    logic [pmqr_pkg::IDX_W-1:0]    pixel_bottom_right;

    modport source (output valid, cmd, entry_index, entry_red, entry_green, entry_blue,
                    pixel_top_left, pixel_top_right, pixel_bottom_left,
                    pixel_bottom_right, input ready);
    modport sink (input valid, cmd, entry_index, entry_red, entry_green, entry_blue,
                  pixel_top_left, pixel_top_right, pixel_bottom_left,
                  pixel_bottom_right, output ready);
endinterface

interface pmqr_out_if;
    logic                       valid;
    logic                       ready;
    logic [pmqr_pkg::IDX_W-1:0] reduced_index;

    modport source (output valid, reduced_index, input ready);
    modport sink (input valid, reduced_index, output ready);
endinterface

interface pmqr_cfg_if;
    logic valid;
    logic ready;
    logic transparent_mode;

    modport source (output valid, transparent_mode, input ready);
    modport sink (input valid, transparent_mode, output ready);
endinterface

FILE: rtl/pmqr_cell.sv
// One cell of the search row: holds one palette entry and updates the passing item.
// Depends on pmqr_pkg.
module pmqr_cell #(
    parameter int unsigned ID = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmqr_pkg::t_wr    i_wr,
    input  pmqr_pkg::t_token i_tok,
    output pmqr_pkg::t_token o_tok
);

    localparam logic [pmqr_pkg::IDX_W-1:0] ID_CODE = pmqr_pkg::IDX_W'(ID);

    logic [pmqr_pkg::RGB_W-1:0] r_rgb;
    pmqr_pkg::t_token           r_tok;
    pmqr_pkg::t_token           n_tok;

    logic [pmqr_pkg::COL_W-1:0] w_red;
    logic [pmqr_pkg::COL_W-1:0] w_green;
    logic [pmqr_pkg::COL_W-1:0] w_blue;
    logic signed [pmqr_pkg::COL_W:0]     w_dr;
    logic signed [pmqr_pkg::COL_W:0]     w_dg;
    logic signed [pmqr_pkg::COL_W:0]     w_db;
    logic signed [2*pmqr_pkg::COL_W+1:0] w_sr;
    logic signed [2*pmqr_pkg::COL_W+1:0] w_sg;
    logic signed [2*pmqr_pkg::COL_W+1:0] w_sb;
    logic [pmqr_pkg::DIST_W-1:0] w_dist;
    logic                        w_searchable;

    assign w_red   = r_rgb[3*pmqr_pkg::COL_W-1:2*pmqr_pkg::COL_W];
    assign w_green = r_rgb[2*pmqr_pkg::COL_W-1:pmqr_pkg::COL_W];
    assign w_blue  = r_rgb[pmqr_pkg::COL_W-1:0];

    // Squared distance from the quad average to this entry.
    assign w_dr = $signed({1'b0, i_tok.avg_r}) - $signed({1'b0, w_red});
    assign w_dg = $signed({1'b0, i_tok.avg_g}) - $signed({1'b0, w_green});
    assign w_db = $signed({1'b0, i_tok.avg_b}) - $signed({1'b0, w_blue});
    assign w_sr = w_dr * w_dr;
    assign w_sg = w_dg * w_dg;
    assign w_sb = w_db * w_db;
    assign w_dist = pmqr_pkg::DIST_W'(w_sr[pmqr_pkg::SQ_W-1:0])
                  + pmqr_pkg::DIST_W'(w_sg[pmqr_pkg::SQ_W-1:0])
                  + pmqr_pkg::DIST_W'(w_sb[pmqr_pkg::SQ_W-1:0]);

    // The see-through index stays out of the search in transparent mode.
    assign w_searchable = !(i_tok.clear && (ID_CODE == pmqr_pkg::CLEAR_INDEX));

    always_comb begin
        n_tok = i_tok;
        unique case (i_tok.phase)
            pmqr_pkg::PASS_GATHER: begin
                for (int k = 0; k < pmqr_pkg::QUAD; k++) begin
                    if (i_tok.act[k] && (i_tok.pix[k] == ID_CODE)) begin
                        n_tok.sum_r = n_tok.sum_r + pmqr_pkg::SUM_W'(w_red);
                        n_tok.sum_g = n_tok.sum_g + pmqr_pkg::SUM_W'(w_green);
                        n_tok.sum_b = n_tok.sum_b + pmqr_pkg::SUM_W'(w_blue);
                    end
                end
            end
            pmqr_pkg::PASS_SEARCH: begin
                if (w_searchable && (w_dist < i_tok.best_d)) begin
                    n_tok.best_d   = w_dist;
                    n_tok.best_idx = ID_CODE;
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == ID_CODE)) begin
            r_rgb <= i_wr.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/pmqr_chain.sv
// Row of search cells, one per palette entry, each passing the item to the next.
// Depends on pmqr_pkg and pmqr_cell.
module pmqr_chain #(
    parameter int unsigned N = pmqr_pkg::PALETTE_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmqr_pkg::t_wr    i_wr,
    input  pmqr_pkg::t_token i_head,
    output pmqr_pkg::t_token o_tail
);

    pmqr_pkg::t_token w_link [N+1];

    assign w_link[0] = i_head;

    for (genvar g = 0; g < N; g++) begin : g_cell
        pmqr_cell #(
            .ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (i_wr),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign o_tail = w_link[N];

endmodule

FILE: rtl/palette_mip_quad_reducer.sv
// Top level of the palette quad reducer: control sequencer, result register and
// the row of search cells. Depends on pmqr_pkg, the channel interfaces and pmqr_chain.

// The block holds a palette of PALETTE_ENTRIES colours, one per cell of a row of
// search cells, and reduces a 2x2 quad of palette indices to the index of the palette
// colour nearest to the quad's average. A load item writes one palette entry; it gives
// no result, and a load to a slot beyond the palette is dropped. A reduce item is
// handled in two trips of one item down the cell row, one cell per cycle: the first
// trip picks up the colours of the quad's pixels and sums them, the sums are then
// divided by the count of opaque pixels (three or four), and the second trip carries
// the average past every entry, keeping the closest one with the lowest index on
// ties. A quad with two or more see-through pixels in transparent mode has its answer
// 255. One item is worked on at a time; the next one is accepted as soon as the
// previous result sits in the output register, even if it has not been taken yet. The
// palette holds no reset value: a quad must only use entries that have been loaded. The
// transparent_mode register is written through its own channel, which is always ready,
// and must only be changed while the block is idle.
module palette_mip_quad_reducer #(
    parameter int unsigned PALETTE_ENTRIES = pmqr_pkg::PALETTE_ENTRIES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pmqr_in_if.sink    i_in,
    pmqr_out_if.source o_out,
    pmqr_cfg_if.sink   i_cfg
);

    // Control state and configuration.
    pmqr_pkg::t_state r_state;
    pmqr_pkg::t_state n_state;
    logic             r_mode;

    // Item launched into the cell row and the item coming back out of it.
    pmqr_pkg::t_token r_head;
    pmqr_pkg::t_token n_head;
    pmqr_pkg::t_token w_tail;

    // Divide by three when exactly one pixel is see-through, else by four.
    logic r_div3;
    logic n_div3;

    // Result waiting for the output register, and the output register itself.
    logic [pmqr_pkg::IDX_W-1:0] r_res;
    logic [pmqr_pkg::IDX_W-1:0] n_res;
    logic                       r_out_vld;
    logic                       n_out_vld;
    logic [pmqr_pkg::IDX_W-1:0] r_out_idx;
    logic [pmqr_pkg::IDX_W-1:0] n_out_idx;

    logic                                  w_accept;
    pmqr_pkg::t_wr                         w_wr;
    logic [pmqr_pkg::QUAD-1:0][pmqr_pkg::IDX_W-1:0] w_pix;
    logic [pmqr_pkg::QUAD-1:0]             w_act;
    logic [pmqr_pkg::SEE_W-1:0]            w_see;

    assign i_in.ready  = (r_state == pmqr_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_vld;
    assign o_out.reduced_index = r_out_idx;

    // A load item writes its palette slot at the edge where it is accepted.
    assign w_wr.en  = w_accept && (pmqr_pkg::t_cmd'(i_in.cmd) == pmqr_pkg::CMD_LOAD);
    assign w_wr.idx = i_in.entry_index;
    assign w_wr.rgb = {i_in.entry_red, i_in.entry_green, i_in.entry_blue};

    assign w_pix = {i_in.pixel_bottom_right, i_in.pixel_bottom_left,
                    i_in.pixel_top_right, i_in.pixel_top_left};

    // A pixel is opaque unless transparent mode is on and it uses the see-through index.
    always_comb begin
        w_see = '0;
        for (int k = 0; k < pmqr_pkg::QUAD; k++) begin
            w_act[k] = !(r_mode && (w_pix[k] == pmqr_pkg::CLEAR_INDEX));
            w_see    = w_see + pmqr_pkg::SEE_W'(!w_act[k]);
        end
    end

    // Next state, next launched item and result handling.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_head.vld = 1'b0;
        n_div3    = r_div3;
        n_res     = r_res;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out_idx = r_out_idx;

        unique case (r_state)
            pmqr_pkg::ST_IDLE: begin
                if (w_accept && (pmqr_pkg::t_cmd'(i_in.cmd) == pmqr_pkg::CMD_REDUCE)) begin
                    if (w_see >= pmqr_pkg::SEE_TWO) begin
                        // Two or more see-through pixels: the quad is see-through.
                        n_res   = pmqr_pkg::CLEAR_INDEX;
                        n_state = pmqr_pkg::ST_FINISH;
                    end else begin
                        n_head.vld   = 1'b1;
                        n_head.phase = pmqr_pkg::PASS_GATHER;
                        n_head.pix   = w_pix;
                        n_head.act   = w_act;
                        n_head.sum_r = '0;
                        n_head.sum_g = '0;
                        n_head.sum_b = '0;
                        n_head.clear = r_mode;
                        n_div3       = (w_see == pmqr_pkg::SEE_ONE);
                        n_state      = pmqr_pkg::ST_GATHER;
                    end
                end
            end
            pmqr_pkg::ST_GATHER: begin
                if (w_tail.vld) begin
                    // Sums are complete: send the average down the row for the search.
                    n_head          = w_tail;
                    n_head.vld      = 1'b1;
                    n_head.phase    = pmqr_pkg::PASS_SEARCH;
                    n_head.avg_r    = pmqr_pkg::avg_of(w_tail.sum_r, r_div3);
                    n_head.avg_g    = pmqr_pkg::avg_of(w_tail.sum_g, r_div3);
                    n_head.avg_b    = pmqr_pkg::avg_of(w_tail.sum_b, r_div3);
                    n_head.best_d   = pmqr_pkg::DIST_MAX;
                    n_head.best_idx = '0;
                    n_state         = pmqr_pkg::ST_SEARCH;
                end
            end
            pmqr_pkg::ST_SEARCH: begin
                if (w_tail.vld) begin
                    n_res   = w_tail.best_idx;
                    n_state = pmqr_pkg::ST_FINISH;
                end
            end
            pmqr_pkg::ST_FINISH: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_idx = r_res;
                    n_state   = pmqr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmqr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmqr_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_mode    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= i_cfg.transparent_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_div3    <= n_div3;
        r_res     <= n_res;
        r_out_idx <= n_out_idx;
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end
    end

    pmqr_chain #(
        .N (PALETTE_ENTRIES)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_head  (r_head),
        .o_tail  (w_tail)
    );

`ifndef SYNTHESIS
    // An item launched into the row comes out of the last cell after passing every cell in turn.
    a_row_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head.vld |-> ##(PALETTE_ENTRIES) w_tail.vld)
        else $error("item did not leave the cell row on time");

    // Items only come out of the row while the sequencer waits for them.
    a_tail_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |-> (r_state == pmqr_pkg::ST_GATHER || r_state == pmqr_pkg::ST_SEARCH))
        else $error("item left the cell row while none was expected");

    // In transparent mode the search never picks the see-through index.
    a_search_skips_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tail.vld && w_tail.phase == pmqr_pkg::PASS_SEARCH && w_tail.clear)
            |-> (w_tail.best_idx != pmqr_pkg::CLEAR_INDEX))
        else $error("search picked the see-through index");

    // A finished result is never dropped while the output register is still full.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_out_idx)))
        else $error("pending result was overwritten");
`endif

endmodule
